// ===== rtl/gsso_pkg.sv =====
package gsso_pkg;

  // Input selector carried on the request side tuser.
  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SEARCH = 1'b1;

  // Source of the value loaded into the output register.
  localparam logic [1:0] OUT_ORDER = 2'd0;
  localparam logic [1:0] OUT_NF    = 2'd1;
  localparam logic [1:0] OUT_ONE   = 2'd2;

  typedef struct packed {
    logic       load_row;
    logic       capture;
    logic       init;
    logic       pop;
    logic       take_top;
    logic       load_cand;
    logic       push;
    logic       rd_order;
    logic       out_load;
    logic [1:0] out_kind;
  } gsso_cmd_t;

  typedef struct packed {
    logic bad_range;
    logic same;
    logic stack_empty;
    logic at_target;
    logic cand_empty;
    logic emit_last;
    logic out_free;
  } gsso_status_t;

endpackage

// ===== rtl/gsso_datapath.sv =====
module gsso_datapath
  import gsso_pkg::*;
#(
  parameter int NUM_VERTICES = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic [3:0]   row_index,
  input  logic [15:0]  row_bits,
  input  logic [3:0]   start_vertex,
  input  logic [3:0]   target_vertex,
  input  gsso_cmd_t    cmd,
  output gsso_status_t st,
  input  logic         out_ready,
  output logic         out_valid,
  output logic [3:0]   vertex_id,
  output logic         found,
  output logic         last
);

  localparam int VW = $clog2(NUM_VERTICES);
  localparam int CW = $clog2(NUM_VERTICES + 1);
  localparam logic [6:0] NV7 = 7'(NUM_VERTICES);

  // Adjacency rows; valid bits stand in for the all-zero reset contents.
  logic [NUM_VERTICES-1:0] rows [NUM_VERTICES];
  logic [NUM_VERTICES-1:0] row_valid;
  logic [NUM_VERTICES-1:0] row_q;
  logic                    row_q_valid;

  logic [VW-1:0] stk [NUM_VERTICES];
  logic [VW-1:0] stk_q;
  logic [CW-1:0] sp;
  logic [CW-1:0] sp_m1;

  logic [VW-1:0] order [NUM_VERTICES];
  logic [VW-1:0] order_q;
  logic [CW-1:0] oc;
  logic [CW-1:0] eidx;

  logic [NUM_VERTICES-1:0] visited;
  logic [NUM_VERTICES-1:0] cand;
  logic [VW-1:0]           pick;
  logic [VW-1:0]           start_q;
  logic [VW-1:0]           target_q;

  logic          row_in_range;
  logic          stk_we;
  logic [VW-1:0] stk_waddr;
  logic [VW-1:0] stk_wdata;

  assign row_in_range = {3'b000, row_index} < NV7;
  assign sp_m1        = sp - 1'b1;

  assign st.bad_range   = !({3'b000, start_vertex} < NV7) || !({3'b000, target_vertex} < NV7);
  assign st.same        = start_vertex == target_vertex;
  assign st.stack_empty = sp == '0;
  assign st.at_target   = stk_q == target_q;
  assign st.cand_empty  = cand == '0;
  assign st.emit_last   = eidx == oc - 1'b1;
  assign st.out_free    = !out_valid || out_ready;

  // Lowest unvisited neighbor goes first, so pushes run in rising index order.
  always_comb begin
    pick = '0;
    for (int i = NUM_VERTICES - 1; i >= 0; i--) begin
      if (cand[i]) begin
        pick = VW'(i);
      end
    end
  end

  always_comb begin
    stk_we    = cmd.init || cmd.push;
    stk_waddr = cmd.init ? '0 : sp[VW-1:0];
    stk_wdata = cmd.init ? VW'(start_vertex) : pick;
  end

  always_ff @(posedge clk) begin
    if (cmd.load_row && row_in_range) begin
      rows[VW'(row_index)] <= NUM_VERTICES'(row_bits);
    end
    if (cmd.take_top) begin
      row_q <= rows[stk_q];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_valid   <= '0;
      row_q_valid <= 1'b0;
    end else begin
      if (cmd.load_row && row_in_range) begin
        row_valid[VW'(row_index)] <= 1'b1;
      end
      if (cmd.take_top) begin
        row_q_valid <= row_valid[stk_q];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (stk_we) begin
      stk[stk_waddr] <= stk_wdata;
    end
    if (cmd.pop) begin
      stk_q <= stk[sp_m1[VW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_top) begin
      order[oc[VW-1:0]] <= stk_q;
    end
    if (cmd.rd_order) begin
      order_q <= order[eidx[VW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      start_q  <= VW'(start_vertex);
      target_q <= VW'(target_vertex);
    end
    if (cmd.load_cand) begin
      cand <= (row_q_valid ? row_q : '0) & ~visited;
    end else if (cmd.push) begin
      cand <= cand & ~(NUM_VERTICES'(1) << pick);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sp      <= '0;
      oc      <= '0;
      eidx    <= '0;
      visited <= '0;
    end else begin
      if (cmd.init) begin
        sp      <= CW'(1);
        oc      <= '0;
        eidx    <= '0;
        visited <= '0;
      end else begin
        if (cmd.pop) begin
          sp <= sp_m1;
        end
        if (cmd.push) begin
          sp      <= sp + 1'b1;
          visited <= visited | (NUM_VERTICES'(1) << pick);
        end
        if (cmd.take_top) begin
          oc      <= oc + 1'b1;
          visited <= visited | (NUM_VERTICES'(1) << stk_q);
        end
        if (cmd.out_load && cmd.out_kind == OUT_ORDER) begin
          eidx <= eidx + 1'b1;
        end
      end
    end
  end

  // Output register: holds a result until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      case (cmd.out_kind)
        OUT_ORDER: begin
          vertex_id <= 4'(order_q);
          found     <= 1'b1;
          last      <= st.emit_last;
        end
        OUT_ONE: begin
          vertex_id <= 4'(start_q);
          found     <= 1'b1;
          last      <= 1'b1;
        end
        default: begin
          vertex_id <= 4'd0;
          found     <= 1'b0;
          last      <= 1'b1;
        end
      endcase
    end
  end

endmodule

// ===== rtl/gsso_ctrl.sv =====
module gsso_ctrl
  import gsso_pkg::*;
(
  input  logic         clk,
  input  logic         rst,
  input  logic         in_valid,
  input  logic         func,
  input  gsso_status_t st,
  output logic         in_ready,
  output gsso_cmd_t    cmd
);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_NF     = 4'd1;
  localparam logic [3:0] S_ONE    = 4'd2;
  localparam logic [3:0] S_POP    = 4'd3;
  localparam logic [3:0] S_TOP    = 4'd4;
  localparam logic [3:0] S_ROW    = 4'd5;
  localparam logic [3:0] S_PUSH   = 4'd6;
  localparam logic [3:0] S_ORD_RD = 4'd7;
  localparam logic [3:0] S_ORD_WR = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;

  always_comb begin
    state_next = state;
    in_ready   = 1'b0;
    cmd        = '0;
    case (state)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          if (func == FUNC_LOAD) begin
            cmd.load_row = 1'b1;
          end else begin
            cmd.capture = 1'b1;
            if (st.bad_range) begin
              state_next = S_NF;
            end else if (st.same) begin
              state_next = S_ONE;
            end else begin
              cmd.init   = 1'b1;
              state_next = S_POP;
            end
          end
        end
      end
      S_NF: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_NF;
          state_next   = S_IDLE;
        end
      end
      S_ONE: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_ONE;
          state_next   = S_IDLE;
        end
      end
      S_POP: begin
        if (st.stack_empty) begin
          state_next = S_NF;
        end else begin
          cmd.pop    = 1'b1;
          state_next = S_TOP;
        end
      end
      S_TOP: begin
        cmd.take_top = 1'b1;
        state_next   = st.at_target ? S_ORD_RD : S_ROW;
      end
      S_ROW: begin
        cmd.load_cand = 1'b1;
        state_next    = S_PUSH;
      end
      S_PUSH: begin
        if (st.cand_empty) begin
          state_next = S_POP;
        end else begin
          cmd.push = 1'b1;
        end
      end
      S_ORD_RD: begin
        cmd.rd_order = 1'b1;
        state_next   = S_ORD_WR;
      end
      S_ORD_WR: begin
        if (st.out_free) begin
          cmd.out_load = 1'b1;
          cmd.out_kind = OUT_ORDER;
          state_next   = st.emit_last ? S_IDLE : S_ORD_RD;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

// ===== rtl/graph_stack_search_order.sv =====
// Channel  Dir  Signals                          Carries
// s_*      in   s_tvalid s_tready s_tdata s_tuser  load (row) or search request
// m_*      out  m_tvalid m_tready m_tdata m_tuser  visit order result, m_tlast
//                m_tlast                            on the final one
// A load writes one row. A search is accepted; then each popped vertex has its row read and
// its unvisited neighbors pushed one by one (the target stops at its row read). Each result
// is an order memory read, then an output register load. Not-found follows an empty stack;
// a start equal to the target, or either out of range, skips the walk to the output.
// Synchronous reset clears the control state, the row valid bits and the output register.
// A stalled output holds the FSM; no request is taken while a search is still at work.
module graph_stack_search_order
  import gsso_pkg::*;
#(
  parameter int NUM_VERTICES = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  // [3:0] row_index, [19:4] row_bits, [23:20] start_vertex,
  // [27:24] target_vertex, [31:28] zero
  input  logic [31:0] s_tdata,
  // [0] func
  input  logic        s_tuser,
  output logic        m_tvalid,
  input  logic        m_tready,
  // [3:0] vertex_id, [7:4] zero
  output logic [7:0]  m_tdata,
  // [0] found
  output logic        m_tuser,
  output logic        m_tlast
);

  gsso_cmd_t    cmd;
  gsso_status_t st;
  logic [3:0]   vertex_id;

  assign m_tdata = {4'd0, vertex_id};

  gsso_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (s_tvalid),
    .func     (s_tuser),
    .st       (st),
    .in_ready (s_tready),
    .cmd      (cmd)
  );

  gsso_datapath #(
    .NUM_VERTICES (NUM_VERTICES)
  ) u_datapath (
    .clk           (clk),
    .rst           (rst),
    .row_index     (s_tdata[3:0]),
    .row_bits      (s_tdata[19:4]),
    .start_vertex  (s_tdata[23:20]),
    .target_vertex (s_tdata[27:24]),
    .cmd           (cmd),
    .st            (st),
    .out_ready     (m_tready),
    .out_valid     (m_tvalid),
    .vertex_id     (vertex_id),
    .found         (m_tuser),
    .last          (m_tlast)
  );

endmodule

// ===== tb/testbench.sv =====
module testbench
  import gsso_pkg::*;
();

  localparam int NV = 16;
  localparam int QUIET_LIMIT = 3000;
  localparam int HOLD_OFF_CYCLES = 300;
  localparam int ITEMS_PER_PHASE = 85;
  localparam int EXPECT_DEPTH = 8192;

  // Idling modes for the random part.
  localparam int IDLE_NONE = 0;
  localparam int IDLE_SENDER = 1;
  localparam int IDLE_RECEIVER = 2;
  localparam int IDLE_BOTH = 3;

  typedef struct packed {
    logic [3:0] vertex_id;
    logic       found;
    logic       last;
  } visit_t;

  typedef struct packed {
    logic        func;
    logic [3:0]  row_index;
    logic [15:0] row_bits;
    logic [3:0]  start_vertex;
    logic [3:0]  target_vertex;
    logic        typed;
    logic [3:0]  want_vertex;
    logic        want_found;
  } plan_row_t;

  localparam int PLAN_ROWS = 21;
  localparam plan_row_t PLAN [PLAN_ROWS] = '{
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd0,  4'd5,  1'b1, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd7,  4'd7,  1'b1, 4'd7,  1'b1},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd15, 4'd0,  1'b1, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd0,  16'hFFFF, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd15, 16'h0000, 4'd15, 4'd15, 1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd0,  4'd15, 1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd15, 16'hFFFF, 4'd15, 4'd0,  1'b1, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd15, 16'h8001, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd15, 4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd0,  16'h0002, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd1,  16'h0004, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd2,  16'h0001, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd0,  4'd3,  1'b1, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd2,  16'h0009, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd0,  4'd3,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd5,  16'h00C0, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd6,  16'h0100, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd5,  4'd8,  1'b0, 4'd0,  1'b0},
    '{FUNC_LOAD,   4'd0,  16'hFFFE, 4'd0,  4'd0,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd0,  4'd1,  1'b0, 4'd0,  1'b0},
    '{FUNC_SEARCH, 4'd0,  16'h0000, 4'd15, 4'd15, 1'b1, 4'd15, 1'b1}
  };

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;
  logic        s_tuser;
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;
  logic        m_tuser;
  logic        m_tlast;

  logic [15:0] adjacency [NV];
  // Expected results in arrival order; exp_rd chases exp_wr.
  visit_t      expected_visits [EXPECT_DEPTH];
  int          exp_wr;
  int          exp_rd;
  int          mismatches;
  int          idle_mode;
  bit          hold_off_pending;

  graph_stack_search_order #(.NUM_VERTICES(NV)) dut (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .m_tlast(m_tlast)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void add_expected(input visit_t v);
    expected_visits[exp_wr] = v;
    exp_wr = exp_wr + 1;
  endfunction

  // Depth-first walk over the local copy of the graph; records the visit order,
  // or a single not-found result when the target is never popped.
  function automatic void walk_depth_first(input logic [3:0] from_v, input logic [3:0] to_v);
    logic [15:0] seen;
    logic [3:0]  pending [NV];
    logic [3:0]  order [NV];
    logic [3:0]  cur;
    int          order_len;
    int          depth;
    bit          hit;
    if (from_v == to_v) begin
      add_expected(visit_t'{vertex_id: from_v, found: 1'b1, last: 1'b1});
      return;
    end
    seen = '0;
    order_len = 0;
    depth = 1;
    pending[0] = from_v;
    hit = 1'b0;
    while (depth > 0 && !hit) begin
      depth = depth - 1;
      cur = pending[depth];
      if (order_len >= NV) break;
      order[order_len] = cur;
      order_len = order_len + 1;
      seen[cur] = 1'b1;
      if (cur == to_v) begin
        hit = 1'b1;
      end else begin
        for (int j = 0; j < NV; j++) begin
          if (adjacency[cur][j] && !seen[j]) begin
            seen[j] = 1'b1;
            if (depth < NV) begin
              pending[depth] = j[3:0];
              depth = depth + 1;
            end
          end
        end
      end
    end
    if (!hit) begin
      add_expected(visit_t'{vertex_id: 4'd0, found: 1'b0, last: 1'b1});
    end else begin
      for (int k = 0; k < order_len; k++) begin
        add_expected(visit_t'{vertex_id: order[k], found: 1'b1,
                              last: (k == order_len - 1)});
      end
    end
  endfunction

  function automatic bit sender_waits();
    case (idle_mode)
      IDLE_SENDER: return $urandom_range(99) < 77;
      IDLE_BOTH:   return $urandom_range(99) < 26;
      default:     return 1'b0;
    endcase
  endfunction

  function automatic bit receiver_stalls();
    case (idle_mode)
      IDLE_RECEIVER: return $urandom_range(99) < 77;
      IDLE_BOTH:     return $urandom_range(99) < 26;
      default:       return 1'b0;
    endcase
  endfunction

  // Offers one request, waits for it to be taken, then updates the prediction.
  task automatic issue_request(input plan_row_t req);
    @(negedge clk);
    while (sender_waits()) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= req.func;
    s_tdata  <= {4'b0, req.target_vertex, req.start_vertex, req.row_bits, req.row_index};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    if (req.func == FUNC_LOAD) begin
      adjacency[req.row_index] = req.row_bits;
    end else if (req.typed) begin
      add_expected(visit_t'{vertex_id: req.want_vertex, found: req.want_found,
                            last: 1'b1});
    end else begin
      walk_depth_first(req.start_vertex, req.target_vertex);
    end
  endtask

  function automatic plan_row_t random_request();
    plan_row_t req;
    req.func = ($urandom_range(99) < 45) ? FUNC_LOAD : FUNC_SEARCH;
    req.row_index = 4'($urandom_range(NV - 1));
    // Sparse rows give dead ends and unreachable targets; dense ones give short walks.
    case ($urandom_range(9))
      0:       req.row_bits = 16'h0000;
      1:       req.row_bits = 16'hFFFF;
      2, 3, 4, 5: req.row_bits = (16'h1 << $urandom_range(15)) | (16'h1 << $urandom_range(15));
      default: req.row_bits = 16'($urandom);
    endcase
    req.start_vertex = 4'($urandom_range(NV - 1));
    req.target_vertex = 4'($urandom_range(NV - 1));
    req.typed = 1'b0;
    req.want_vertex = 4'd0;
    req.want_found = 1'b0;
    return req;
  endfunction

  // Receiver side: random stalls per idling mode, plus one long hold-off on request.
  initial begin
    int hold_left;
    hold_left = 0;
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_off_pending) begin
        hold_off_pending = 1'b0;
        hold_left = HOLD_OFF_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left = hold_left - 1;
        m_tready <= 1'b0;
      end else begin
        m_tready <= !receiver_stalls();
      end
    end
  end

  always @(posedge clk) begin
    visit_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (exp_rd == exp_wr) begin
        $error("result with nothing expected: vertex_id=%0d found=%0d last=%0d",
               m_tdata[3:0], m_tuser, m_tlast);
        mismatches++;
      end else begin
        want = expected_visits[exp_rd];
        exp_rd = exp_rd + 1;
        if (m_tdata[3:0] !== want.vertex_id) begin
          $error("vertex_id: expected %0d, actual %0d", want.vertex_id, m_tdata[3:0]);
          mismatches++;
        end
        if (m_tuser !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, m_tuser);
          mismatches++;
        end
        if (m_tlast !== want.last) begin
          $error("last: expected %0d, actual %0d", want.last, m_tlast);
          mismatches++;
        end
      end
    end
  end

  // Ends the run when neither side has moved anything for too long.
  initial begin
    int quiet_cycles;
    quiet_cycles = 0;
    while (quiet_cycles < QUIET_LIMIT) begin
      @(posedge clk);
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready)) quiet_cycles = 0;
      else quiet_cycles++;
    end
    $display("end of test: mismatches");
    $finish;
  end

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tuser = FUNC_LOAD;
    exp_wr = 0;
    exp_rd = 0;
    mismatches = 0;
    idle_mode = IDLE_NONE;
    hold_off_pending = 1'b0;
    foreach (adjacency[i]) adjacency[i] = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    for (int r = 0; r < PLAN_ROWS; r++) issue_request(PLAN[r]);

    for (int phase = IDLE_NONE; phase <= IDLE_BOTH; phase++) begin
      idle_mode = phase;
      // With the output held off, searches back up until the input stalls.
      if (phase == IDLE_NONE) hold_off_pending = 1'b1;
      for (int n = 0; n < ITEMS_PER_PHASE; n++) issue_request(random_request());
    end

    @(negedge clk);
    s_tvalid <= 1'b0;
    while (exp_rd != exp_wr) @(posedge clk);
    repeat (120) @(posedge clk);

    if (mismatches == 0 && exp_rd == exp_wr) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/gsso_pkg.sv
rtl/gsso_datapath.sv
rtl/gsso_ctrl.sv
rtl/graph_stack_search_order.sv
tb/testbench.sv
